### sv/gwm_pkg.sv
// Glob wildcard matcher: shared types and constants.
// Used by gwm_cell and glob_wildcard_matcher_core; no dependencies.
`default_nettype none

package gwm_pkg;

    // Pattern metacharacters
    localparam logic [7:0] CHAR_ANY = 8'h3F;  // '?'
    localparam logic [7:0] CHAR_RUN = 8'h2A;  // '*'

    // Configuration register map
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_LEN_W      = 6;
    localparam int PAT_WORDS      = 4;
    localparam int BYTES_PER_WORD = 8;
    localparam int PAT_BYTES      = PAT_WORDS * BYTES_PER_WORD;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD0  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD1  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD2  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD3  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic step;      // consume a text byte, keep result
        logic restart;   // load start set (text ended)
        logic byte_in;   // item carries a text byte
    } cell_ctrl_t;

endpackage

`default_nettype wire

### sv/gwm_cell.sv
// One NFA position of the glob matcher: pattern byte plus active bit.
// Chained to its neighbors; depends on gwm_pkg.
`default_nettype none

module gwm_cell #(
    parameter int INDEX = 0,
    parameter int LEN_W = 6
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire gwm_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]          text_byte,
    input  wire logic                pat_we,
    input  wire logic [7:0]          pat_wdata,
    input  wire logic [LEN_W-1:0]    pat_len,
    input  wire logic                adv_in,
    input  wire logic                clo_in,
    input  wire logic                pre_in,
    output logic                     adv_out,
    output logic                     clo_out,
    output logic                     pre_out,
    output logic                     hit_out
);

    logic [7:0] pat_reg;
    logic       act_reg;
    logic       act_next;

    logic in_use;
    logic is_end;
    logic is_star;
    logic is_any;
    logic cur;
    logic nxt;
    logic closed;

    always_comb begin
        in_use  = LEN_W'(INDEX) < pat_len;
        is_end  = LEN_W'(INDEX) == pat_len;
        is_star = pat_reg == gwm_pkg::CHAR_RUN;
        is_any  = pat_reg == gwm_pkg::CHAR_ANY;

        // held bit, dropped past the length, closed over stars of the current pattern
        cur     = (act_reg & (in_use | is_end)) | pre_in;
        pre_out = cur & in_use & is_star;

        // byte step: a star holds its position, a literal or '?' advances
        adv_out = cur & in_use & ~is_star & (is_any | (pat_reg == text_byte));
        nxt     = pre_out | adv_in;

        // forward star closure of the new set ripples from cell to cell
        closed  = nxt | clo_in;
        clo_out = closed & in_use & is_star;

        hit_out = is_end & (ctrl.byte_in ? closed : cur);

        act_next = act_reg;
        if (ctrl.restart) begin
            act_next = (INDEX == 0);
        end else if (ctrl.step) begin
            act_next = closed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg <= 8'h00;
            act_reg <= (INDEX == 0);
        end else begin
            if (pat_we) begin
                pat_reg <= pat_wdata;
            end
            act_reg <= act_next;
        end
    end

endmodule

`default_nettype wire

### sv/glob_wildcard_matcher_core.sv
// Glob wildcard matcher top level: config registers, result register, cell chain.
// Depends on gwm_pkg and gwm_cell.
`default_nettype none

// Streams a text one byte per item and matches it against a glob pattern of
// up to PATTERN_MAX bytes ('*' = any run incl. empty, '?' = any one byte,
// other bytes literal, case-sensitive). The verdict (m_matched) is one result
// item for each input item with s_last set; an empty text is a single item
// with s_byte_valid low and s_last high. Items without s_last and without a
// valid byte are dropped. Throughput is one item per clock while the result
// side keeps up: each cell holds one NFA position, and the star closure of
// the held set, the byte step and the closure of the new set ripple through
// the chain in the same cycle, so the critical path grows linearly with
// PATTERN_MAX. m_valid rises in the cycle after a last item is accepted.
// The single result register frees as it is read, so s_ready drops only
// while a verdict waits with m_ready low, and then every input item waits.
// Pattern words/length are written over the cfg_wr_* port while no item is
// offered; a write takes effect at its clock edge with no stall. The held
// active set is cleared above the current length and star-closed against the
// current pattern each time an item uses it, so it survives a pattern change
// mid-text. pattern_length saturates at PATTERN_MAX; pattern bytes that no
// word register reaches stay zero.
module glob_wildcard_matcher_core #(
    parameter int PATTERN_MAX = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_wr_en,
    input  wire logic [gwm_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  wire logic [gwm_pkg::CFG_DATA_W-1:0]    cfg_wr_data,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_text_byte,
    input  wire logic                              s_byte_valid,
    input  wire logic                              s_last,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_matched
);

    localparam int NUM_POS = PATTERN_MAX + 1;
    localparam int LEN_W   = $clog2(PATTERN_MAX + 1);

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             m_valid_reg;
    logic             m_matched_reg;

    logic                accept;
    gwm_pkg::cell_ctrl_t ctrl;
    logic [6:0]          len_raw;

    // chain links between neighboring cells
    logic [NUM_POS-1:0] adv_link;
    logic [NUM_POS-1:0] clo_link;
    logic [NUM_POS-1:0] pre_link;
    logic [NUM_POS-1:0] hit;
    logic [NUM_POS-1:0] pat_we;
    logic [7:0]         pat_wdata [NUM_POS];

    assign s_ready   = ~m_valid_reg | m_ready;
    assign accept    = s_valid & s_ready;
    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;

    always_comb begin
        ctrl.step    = accept & s_byte_valid & ~s_last;
        ctrl.restart = accept & s_last;
        ctrl.byte_in = s_byte_valid;

        len_raw  = {1'b0, cfg_wr_data[gwm_pkg::CFG_LEN_W-1:0]};
        len_next = (len_raw > 7'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : LEN_W'(len_raw);
    end

    assign adv_link[0] = 1'b0;
    assign clo_link[0] = 1'b0;
    assign pre_link[0] = 1'b0;

    genvar p;
    generate
        for (p = 0; p < NUM_POS; p++) begin : g_cell
            // byte lane select for positions a word register reaches
            if (p < gwm_pkg::PAT_BYTES && p < PATTERN_MAX) begin : g_we
                assign pat_we[p] = cfg_wr_en &&
                    (cfg_wr_index == gwm_pkg::REG_PATTERN_WORD0
                                     + gwm_pkg::CFG_INDEX_W'(p / gwm_pkg::BYTES_PER_WORD));
                assign pat_wdata[p] =
                    cfg_wr_data[8*(p % gwm_pkg::BYTES_PER_WORD) +: 8];
            end else begin : g_no_we
                assign pat_we[p]    = 1'b0;
                assign pat_wdata[p] = 8'h00;
            end

            if (p < NUM_POS - 1) begin : g_mid
                gwm_cell #(
                    .INDEX (p),
                    .LEN_W (LEN_W)
                ) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .ctrl      (ctrl),
                    .text_byte (s_text_byte),
                    .pat_we    (pat_we[p]),
                    .pat_wdata (pat_wdata[p]),
                    .pat_len   (len_reg),
                    .adv_in    (adv_link[p]),
                    .clo_in    (clo_link[p]),
                    .pre_in    (pre_link[p]),
                    .adv_out   (adv_link[p+1]),
                    .clo_out   (clo_link[p+1]),
                    .pre_out   (pre_link[p+1]),
                    .hit_out   (hit[p])
                );
            end else begin : g_tail
                // final position: end of chain, links out left open
                gwm_cell #(
                    .INDEX (p),
                    .LEN_W (LEN_W)
                ) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .ctrl      (ctrl),
                    .text_byte (s_text_byte),
                    .pat_we    (pat_we[p]),
                    .pat_wdata (pat_wdata[p]),
                    .pat_len   (len_reg),
                    .adv_in    (adv_link[p]),
                    .clo_in    (clo_link[p]),
                    .pre_in    (pre_link[p]),
                    .adv_out   (),
                    .clo_out   (),
                    .pre_out   (),
                    .hit_out   (hit[p])
                );
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_wr_index == gwm_pkg::REG_PATTERN_LENGTH) begin
                len_reg <= len_next;
            end
            if (accept && s_last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // verdict: end position reached after the last byte
    always_ff @(posedge aclk) begin
        if (accept && s_last) begin
            m_matched_reg <= |hit;
        end
    end

`ifndef NO_ASSERTIONS
    // a last item always produces a verdict in the next cycle
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> m_valid)
        else $error("verdict missing after last item");

    // a verdict only appears after a last item was taken
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_last))
        else $error("verdict without a last item");

    // a waiting verdict stays put until taken
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_matched)))
        else $error("verdict dropped or changed while waiting");

    // input is only held off by a waiting verdict
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no verdict waiting");
`endif

endmodule

`default_nettype wire
